@@ hw/rtl/mlrt_pkg.sv @@
// Shared types and constants for the multi-lane race timer.
// No dependencies; imported by every module of the block.
package mlrt_pkg;

    localparam int LANE_COUNT          = 4;
    localparam int LANE_W              = 2;
    localparam int COUNTER_WIDTH_DEF   = 32;
    localparam int RESULT_W            = 32;
    localparam int NUM_W               = 36;
    localparam int STEP_W              = $clog2(NUM_W);

    localparam int S_TDATA_W           = 8;
    localparam int M_TDATA_W           = 72;
    localparam int CFG_INDEX_W         = 8;
    localparam int CFG_DATA_W          = 36;

    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUMERATOR = 8'd1;

    localparam logic [RESULT_W-1:0] TIMEOUT_RESET   = 32'd1440000000;
    localparam logic [NUM_W-1:0]    NUMERATOR_RESET = 36'd36504000000;

    typedef enum logic [1:0] {
        ST_TRACK,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } mlrt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mlrt_div_stat_t;

endpackage

@@ hw/rtl/mlrt_divider.sv @@
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per divide.
// Depends on mlrt_pkg.
module mlrt_divider import mlrt_pkg::*; #(
    parameter int DIVISOR_W = COUNTER_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output mlrt_div_stat_t       stat,
    output logic [NUM_W-1:0]     quotient
);

    logic [NUM_W-1:0]     quot_reg, quot_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    always_comb begin
        shifted = {rem_reg, quot_reg[NUM_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});

        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = STEP_W'(NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

@@ hw/rtl/mlrt_tracker.sv @@
// Tick counter, race arming, per-lane finish stamps and timeout detect.
// Depends on mlrt_pkg.
module mlrt_tracker import mlrt_pkg::*; #(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     tick,
    input  logic                     start_edge,
    input  logic [LANE_COUNT-1:0]    finish_edges,
    input  logic [RESULT_W-1:0]      timeout_cycles,
    input  logic [LANE_W-1:0]        rd_lane,
    output logic                     race_end,
    output logic                     rd_done,
    output logic [COUNTER_WIDTH-1:0] rd_elapsed
);

    localparam int CMP_W = (COUNTER_WIDTH > RESULT_W) ? COUNTER_WIDTH : RESULT_W;

    logic [COUNTER_WIDTH-1:0] counter_reg, counter_next;
    logic [COUNTER_WIDTH-1:0] start_reg, start_next;
    logic                     running_reg, running_next;
    logic [LANE_COUNT-1:0]    done_reg, done_next;
    logic [COUNTER_WIDTH-1:0] stamp_reg [LANE_COUNT];

    logic [LANE_COUNT-1:0]    fin_new;
    logic [LANE_COUNT-1:0]    done_merge;
    logic [COUNTER_WIDTH-1:0] elapsed_now;
    logic                     timeout_hit;

    always_comb begin
        fin_new     = finish_edges & ~done_reg;
        done_merge  = done_reg | finish_edges;
        elapsed_now = counter_reg - start_reg;
        timeout_hit = CMP_W'(elapsed_now) > CMP_W'(timeout_cycles);
        race_end    = tick && running_reg && ((&done_merge) || timeout_hit);

        counter_next = counter_reg;
        start_next   = start_reg;
        running_next = running_reg;
        done_next    = done_reg;
        if (tick) begin
            counter_next = counter_reg + 1'b1;
            if (!running_reg) begin
                if (start_edge) begin
                    start_next   = counter_reg;
                    done_next    = '0;
                    running_next = 1'b1;
                end
            end else begin
                done_next = done_merge;
                if (race_end) begin
                    running_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            start_reg   <= '0;
            running_reg <= 1'b0;
            done_reg    <= '0;
        end else begin
            counter_reg <= counter_next;
            start_reg   <= start_next;
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    // first finish of each lane only
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (tick && running_reg && fin_new[i]) begin
                stamp_reg[i] <= counter_reg;
            end
        end
    end

    assign rd_done    = done_reg[rd_lane];
    assign rd_elapsed = stamp_reg[rd_lane] - start_reg;

endmodule

@@ hw/rtl/multi_lane_race_timer_unit.sv @@
// Multi-lane race timer: each accepted s_ transfer is one timebase tick, one per cycle
// while s_tready is high. At race end s_tready drops and the four lane results are
// produced in turn: per lane a prep step, a divide giving 36 quotient bits (finished
// nonzero-time lanes only) and a load step that waits out any m_tready stall.
// Reset: synchronous active-low aresetn clears counter, race state, sequencer
// and m_tvalid; config registers return to their defaults. No clearing pass.
module multi_lane_race_timer_unit import mlrt_pkg::*; #(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // input ticks
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [0] start_edge, [4:1] finish_edges, rest 0

    // per-lane results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [1:0] lane, [33:2] elapsed_cycles,
                                              // [34] did_not_finish, [66:35] speed_mph
    output logic                   m_tlast,   // last: final lane of the race

    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CMP_W = (COUNTER_WIDTH > RESULT_W) ? COUNTER_WIDTH : RESULT_W;
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANE_COUNT - 1);

    // ---------------------------------------------------------------
    // Configuration registers, always writable
    // ---------------------------------------------------------------
    logic [RESULT_W-1:0] timeout_reg, timeout_next;
    logic [NUM_W-1:0]    numerator_reg, numerator_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        timeout_next   = timeout_reg;
        numerator_next = numerator_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_TIMEOUT:   timeout_next   = cfg_data[RESULT_W-1:0];
                REG_NUMERATOR: numerator_next = cfg_data[NUM_W-1:0];
                default:       ;  // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            numerator_reg <= NUMERATOR_RESET;
        end else begin
            timeout_reg   <= timeout_next;
            numerator_reg <= numerator_next;
        end
    end

    // ---------------------------------------------------------------
    // Race tracking
    // ---------------------------------------------------------------
    mlrt_state_t state_reg, state_next;
    logic [LANE_W-1:0] lane_reg, lane_next;

    logic                     tick;
    logic                     race_end;
    logic                     rd_done;
    logic [COUNTER_WIDTH-1:0] rd_elapsed;

    assign tick = s_tvalid && s_tready;

    mlrt_tracker #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_tracker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (tick),
        .start_edge     (s_tdata[0]),
        .finish_edges   (s_tdata[LANE_COUNT:1]),
        .timeout_cycles (timeout_reg),
        .rd_lane        (lane_reg),
        .race_end       (race_end),
        .rd_done        (rd_done),
        .rd_elapsed     (rd_elapsed)
    );

    // ---------------------------------------------------------------
    // Shared speed divider
    // ---------------------------------------------------------------
    logic           div_start;
    mlrt_div_stat_t div_stat;
    logic [NUM_W-1:0] quotient;

    mlrt_divider #(
        .DIVISOR_W (COUNTER_WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (numerator_reg),
        .divisor  (rd_elapsed),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // ---------------------------------------------------------------
    // Result sequencer
    // ---------------------------------------------------------------
    logic out_free;
    logic el_zero;
    logic out_load;

    assign out_free = !m_tvalid || m_tready;
    assign el_zero  = (rd_elapsed == '0);

    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        case (state_reg)
            ST_TRACK: begin
                if (race_end) begin
                    state_next = ST_PREP;
                    lane_next  = '0;
                end
            end
            ST_PREP: begin
                // unfinished lanes and a zero time need no divide
                state_next = (rd_done && !el_zero) ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (lane_reg == LAST_LANE) begin
                        state_next = ST_TRACK;
                    end else begin
                        state_next = ST_PREP;
                        lane_next  = lane_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_TRACK;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_TRACK: s_tready  = 1'b1;
            ST_PREP:  div_start = rd_done && !el_zero;
            ST_DIV:   ;
            ST_EMIT:  out_load  = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_TRACK;
            lane_reg  <= '0;
        end else begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [CMP_W-1:0]    el_wide;
    logic [RESULT_W-1:0] el_out;
    logic [RESULT_W-1:0] speed_out;
    logic                dnf_out;

    always_comb begin
        el_wide = CMP_W'(rd_elapsed);
        dnf_out = !rd_done;
        el_out  = rd_done ? el_wide[RESULT_W-1:0] : '0;
        if (!rd_done) begin
            speed_out = '0;
        end else if (el_zero || (quotient[NUM_W-1:RESULT_W] != '0)) begin
            speed_out = '1;  // saturate
        end else begin
            speed_out = quotient[RESULT_W-1:0];
        end
    end

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0, speed_out, dnf_out, el_out, lane_reg};
            m_tlast_next  = (lane_reg == LAST_LANE);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // the tick that ends a race blocks further ticks until results are out
    a_end_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick && race_end) |=> !s_tready)
        else $error("tick accepted right after race end");

    // last flag matches the final lane number
    a_last_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == LAST_LANE)))
        else $error("m_tlast does not match lane");

    // an unfinished lane reports zero time and speed
    a_dnf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34]) |-> ((m_tdata[33:2] == '0) && (m_tdata[66:35] == '0)))
        else $error("did-not-finish result with nonzero time or speed");

    // divider is never restarted mid-divide
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule
